### src/scti_pkg.sv
`default_nettype none

package scti_pkg;

    localparam int unsigned AngleW = 16;
    localparam int unsigned QuadW  = 2;
    localparam int unsigned IdxW   = 6;
    localparam int unsigned FracW  = AngleW - QuadW - IdxW;
    localparam int unsigned ValueW = 16;
    localparam int unsigned TblW   = 16;
    localparam int unsigned TblIdxW = IdxW + 1;

    localparam logic [AngleW-1:0] QuarterTurn = 16'h4000;
    localparam logic [TblIdxW-1:0] TblLast = 7'd64;

    // quarter-wave sine table, 32768 stands for one
    function automatic logic [TblW-1:0] quarter_wave(input logic [TblIdxW-1:0] idx);
        logic [TblW-1:0] v;
        case (idx)
            7'd0:  v = 16'd0;     7'd1:  v = 16'd804;   7'd2:  v = 16'd1608;
            7'd3:  v = 16'd2411;  7'd4:  v = 16'd3212;  7'd5:  v = 16'd4011;
            7'd6:  v = 16'd4808;  7'd7:  v = 16'd5602;  7'd8:  v = 16'd6393;
            7'd9:  v = 16'd7180;  7'd10: v = 16'd7962;  7'd11: v = 16'd8740;
            7'd12: v = 16'd9513;  7'd13: v = 16'd10279; 7'd14: v = 16'd11040;
            7'd15: v = 16'd11794; 7'd16: v = 16'd12540; 7'd17: v = 16'd13280;
            7'd18: v = 16'd14011; 7'd19: v = 16'd14734; 7'd20: v = 16'd15448;
            7'd21: v = 16'd16152; 7'd22: v = 16'd16847; 7'd23: v = 16'd17532;
            7'd24: v = 16'd18206; 7'd25: v = 16'd18869; 7'd26: v = 16'd19521;
            7'd27: v = 16'd20161; 7'd28: v = 16'd20789; 7'd29: v = 16'd21404;
            7'd30: v = 16'd22007; 7'd31: v = 16'd22596; 7'd32: v = 16'd23172;
            7'd33: v = 16'd23733; 7'd34: v = 16'd24281; 7'd35: v = 16'd24813;
            7'd36: v = 16'd25331; 7'd37: v = 16'd25834; 7'd38: v = 16'd26321;
            7'd39: v = 16'd26792; 7'd40: v = 16'd27247; 7'd41: v = 16'd27686;
            7'd42: v = 16'd28107; 7'd43: v = 16'd28512; 7'd44: v = 16'd28900;
            7'd45: v = 16'd29271; 7'd46: v = 16'd29623; 7'd47: v = 16'd29958;
            7'd48: v = 16'd30275; 7'd49: v = 16'd30574; 7'd50: v = 16'd30854;
            7'd51: v = 16'd31116; 7'd52: v = 16'd31359; 7'd53: v = 16'd31583;
            7'd54: v = 16'd31788; 7'd55: v = 16'd31973; 7'd56: v = 16'd32140;
            7'd57: v = 16'd32287; 7'd58: v = 16'd32415; 7'd59: v = 16'd32523;
            7'd60: v = 16'd32612; 7'd61: v = 16'd32681; 7'd62: v = 16'd32730;
            7'd63: v = 16'd32760; 7'd64: v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/scti_interp.sv
`default_nettype none

module scti_interp (
    input  wire logic [scti_pkg::AngleW-1:0]        i_angle,
    input  wire logic                               i_mode,
    output      logic signed [scti_pkg::ValueW-1:0] o_value
);

    logic [scti_pkg::AngleW-1:0]  ang;
    logic [scti_pkg::QuadW-1:0]   quad;
    logic [scti_pkg::IdxW-1:0]    idx;
    logic [scti_pkg::FracW-1:0]   frac;
    logic [scti_pkg::TblIdxW-1:0] lo_idx;
    logic [scti_pkg::TblIdxW-1:0] hi_idx;
    logic [scti_pkg::TblW-1:0]    lo;
    logic [scti_pkg::TblW-1:0]    hi;
    logic signed [16:0]           diff;
    logic signed [25:0]           prod;
    logic signed [25:0]           mag;
    logic signed [25:0]           sum;

    always_comb begin
        ang  = i_mode ? i_angle + scti_pkg::QuarterTurn : i_angle;
        quad = ang[15:14];
        idx  = ang[13:8];
        frac = ang[7:0];
        // odd quadrants walk the table backwards
        if (quad[0]) begin
            lo_idx = scti_pkg::TblLast - {1'b0, idx};
            hi_idx = scti_pkg::TblLast - 7'd1 - {1'b0, idx};
        end else begin
            lo_idx = {1'b0, idx};
            hi_idx = {1'b0, idx} + 7'd1;
        end
        lo   = scti_pkg::quarter_wave(lo_idx);
        hi   = scti_pkg::quarter_wave(hi_idx);
        // lo*(256-f) + hi*f folded into one multiply
        diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
        prod = diff * $signed({1'b0, frac});
        mag  = $signed({2'b00, lo, 8'h00}) + prod;
        // lower half of the turn is negated
        sum  = (quad[1] ? -mag : mag) + 26'sd256;
        o_value = sum[24:9];
    end

endmodule

`default_nettype wire

### src/sine_cosine_table_interp.sv
// sine / cosine by quarter-wave table with linear interpolation
//
// input channel: i_in_valid / o_in_ready carry i_angle (one 65536th of a turn)
// and i_mode (0 sine, 1 cosine); a transfer happens when both are high
// output channel: o_out_valid / i_out_ready carry o_value, signed, 16384 = one
//
// path: input register, then lookup + interpolation, then result register
// throughput: one item per cycle while the receiver takes results; the single
// multiply sits between the two registers and no item depends on another
//
// reset (synchronous, active low) empties both stages; payload registers
// keep whatever they held
//
// when the receiver stalls the result register holds its value, the input
// register still fills once, and o_in_ready drops only when both stages
// are full
`default_nettype none

module sine_cosine_table_interp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire logic [scti_pkg::AngleW-1:0]        i_angle,
    input  wire logic                               i_mode,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      logic signed [scti_pkg::ValueW-1:0] o_value
);

    // input stage
    logic                               r_s1_valid;
    logic [scti_pkg::AngleW-1:0]        r_angle;
    logic                               r_mode;
    // result stage
    logic                               r_out_valid;
    logic signed [scti_pkg::ValueW-1:0] r_value;

    logic                               s2_ready;
    logic                               s1_ready;
    logic signed [scti_pkg::ValueW-1:0] calc_value;

    assign s2_ready = !r_out_valid || i_out_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    scti_interp u_interp (
        .i_angle (r_angle),
        .i_mode  (r_mode),
        .o_value (calc_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_angle <= i_angle;
            r_mode  <= i_mode;
        end
        if (s2_ready && r_s1_valid) begin
            r_value <= calc_value;
        end
    end

    assign o_in_ready  = s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

endmodule

`default_nettype wire

### src/scti_checker.sv
`default_nettype none

module scti_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire logic [scti_pkg::AngleW-1:0]        i_angle,
    input wire logic                               i_mode,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire logic signed [scti_pkg::ValueW-1:0] o_value
);

    // reset leaves the result side empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // results stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_value <= 16'sd16384) && (o_value >= -16'sd16384))
        else $error("result out of range");

    // an empty result stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // a transfer shows up as a valid result when the receiver takes results
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready |=> o_out_valid)
        else $error("result missing two cycles after transfer");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_value)))
        else $error("stalled result changed");

endmodule

bind sine_cosine_table_interp scti_checker u_scti_checker (.*);

`default_nettype wire
